>>> hw/rtl/fifo_with_indexed_remove_assert.svh
// Assertion macros for the indexed-remove FIFO.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef FIFO_WITH_INDEXED_REMOVE_ASSERT_SVH
`define FIFO_WITH_INDEXED_REMOVE_ASSERT_SVH

// Property that must hold on every enabled clock edge.
`define FWIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FWIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fwir_pkg.sv
// Shared constants and types for the indexed-remove FIFO.
// No dependencies.
package fwir_pkg;

  localparam int MODE_W  = 3;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  // Per-slot control: load the incoming word, or take the right neighbour's word.
  typedef struct packed {
    logic load;
    logic shift;
  } slot_ctl_t;

endpackage

>>> hw/rtl/fwir_req_if.sv
// Request channel of the indexed-remove FIFO: valid/ready plus request payload.
// Depends on fwir_pkg.
interface fwir_req_if;
  logic                         valid;
  logic                         ready;
  logic [fwir_pkg::MODE_W-1:0]  mode;
  logic [fwir_pkg::WORD_W-1:0]  data_in;
  logic [fwir_pkg::POS_W-1:0]   position;

  modport source (output valid, output mode, output data_in, output position, input ready);
  modport sink   (input valid, input mode, input data_in, input position, output ready);
endinterface

>>> hw/rtl/fwir_rsp_if.sv
// Result channel of the indexed-remove FIFO: valid/ready plus result payload.
// Depends on fwir_pkg.
interface fwir_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fwir_pkg::WORD_W-1:0]   data_out;
  logic                          found;
  logic                          push_dropped;
  logic [fwir_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output data_out, output found, output push_dropped,
                  output entry_count, input ready);
  modport sink   (input valid, input data_out, input found, input push_dropped,
                  input entry_count, output ready);
endinterface

>>> hw/rtl/fwir_slot.sv
// One storage slot of the FIFO chain: holds a word, loads a pushed word or
// takes its right neighbour's word when a gap closes. Depends on fwir_pkg.
module fwir_slot #(
  parameter int W = 32
) (
  input  logic                clk,
  input  fwir_pkg::slot_ctl_t ctl,
  input  logic [W-1:0]        tail_data,
  input  logic [W-1:0]        right_data,
  output logic [W-1:0]        data
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= tail_data;
    end else if (ctl.shift) begin
      data <= right_data;
    end
  end

endmodule

>>> hw/rtl/fifo_with_indexed_remove.sv
// Bounded FIFO with removal at any position. The queue is a row of DEPTH slots,
// position 0 at the head; a push loads the slot at the tail, a pop or remove
// makes every slot from the removed position onward take its right neighbour's
// word in the same cycle. One request is taken per cycle and its result appears
// in the output register on the following cycle; a request is taken only while
// that register is empty or being drained, so a stalled result holds off the
// next request. Only the first 16 positions are addressable; entry_count gives
// the low five bits of the count. No clearing pass after reset.
// Depends on fwir_pkg, fwir_req_if, fwir_rsp_if, fwir_slot and the assert header.
`include "fifo_with_indexed_remove_assert.svh"

module fifo_with_indexed_remove #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  fwir_req_if.sink   req,
  fwir_rsp_if.source rsp
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > fwir_pkg::POS_W) ? CW : fwir_pkg::POS_W;
  localparam int RD_N  = (DEPTH < (1 << fwir_pkg::POS_W)) ? DEPTH : (1 << fwir_pkg::POS_W);

  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic                           out_valid;
  logic [fwir_pkg::WORD_W-1:0]    out_data;
  logic                           out_found;
  logic                           out_dropped;
  logic [fwir_pkg::COUNT_W-1:0]   out_count;

  logic                           acc;
  logic                           push_ok;
  logic                           rm_ok;
  logic                           found_c;
  logic                           dropped_c;
  logic [fwir_pkg::POS_W-1:0]     rd_pos;
  logic [CMP_W-1:0]               rd_pos_c;
  logic [DATA_WIDTH-1:0]          rd_data;
  logic [DATA_WIDTH-1:0]          din;

  logic [DATA_WIDTH-1:0]          slot_q   [DEPTH];
  fwir_pkg::slot_ctl_t            slot_ctl [DEPTH];

  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign din       = DATA_WIDTH'(req.data_in);
  assign rd_pos_c  = CMP_W'(rd_pos);

  // Request decode against the current count.
  always_comb begin
    push_ok   = 1'b0;
    rm_ok     = 1'b0;
    found_c   = 1'b0;
    dropped_c = 1'b0;
    rd_pos    = req.position;
    case (req.mode)
      fwir_pkg::MODE_PUSH: begin
        if (count < CW'(DEPTH)) push_ok = 1'b1;
        else dropped_c = 1'b1;
      end
      fwir_pkg::MODE_POP: begin
        rd_pos  = '0;
        found_c = (count != '0);
        rm_ok   = found_c;
      end
      fwir_pkg::MODE_REMOVE: begin
        found_c = (CMP_W'(req.position) < CMP_W'(count));
        rm_ok   = found_c;
      end
      fwir_pkg::MODE_PEEK: begin
        rd_pos  = '0;
        found_c = (count != '0);
      end
      fwir_pkg::MODE_READ: begin
        found_c = (CMP_W'(req.position) < CMP_W'(count));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (acc && push_ok) count_next = count + CW'(1);
    else if (acc && rm_ok) count_next = count - CW'(1);
  end

  // Read select over the addressable head slots.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (rd_pos == fwir_pkg::POS_W'(i)) rd_data = slot_q[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    logic [DATA_WIDTH-1:0] right;
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = slot_q[g+1];
    end

    assign slot_ctl[g].load  = acc && push_ok && (count == CW'(g));
    assign slot_ctl[g].shift = acc && rm_ok && (CMP_W'(g) >= rd_pos_c);

    fwir_slot #(.W(DATA_WIDTH)) u_slot (
      .clk        (clk),
      .ctl        (slot_ctl[g]),
      .tail_data  (din),
      .right_data (right),
      .data       (slot_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (acc) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data    <= found_c ? fwir_pkg::WORD_W'(rd_data) : '0;
      out_found   <= found_c;
      out_dropped <= dropped_c;
      out_count   <= fwir_pkg::COUNT_W'(count_next);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.data_out     = out_data;
  assign rsp.found        = out_found;
  assign rsp.push_dropped = out_dropped;
  assign rsp.entry_count  = out_count;

  `FWIR_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `FWIR_ASSERT(a_stall_blocks, !(rsp.valid && !rsp.ready && req.ready), "taken while stalled")
  `FWIR_ASSERT(a_found_xor_drop, !(rsp.valid && rsp.found && rsp.push_dropped), "found with drop")
  `FWIR_ASSERT(a_miss_zero, !(rsp.valid && !rsp.found && rsp.data_out != '0), "data on a miss")
  `FWIR_ASSERT_NEXT(a_push_grows, acc && push_ok, count == $past(count) + CW'(1), "no push growth")

endmodule

>>> bench/fifo_with_indexed_remove_checker.sv
// Scoreboard for the indexed-remove FIFO: watches the request and result channels,
// predicts each result from its own copy of the queue and compares it.
// Depends on fwir_pkg, fwir_req_if and fwir_rsp_if.
module fifo_with_indexed_remove_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  fwir_req_if  req,
  fwir_rsp_if  rsp,
  output int   errors,
  output int   pending,
  output int   fill
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = $clog2(DEPTH);

  typedef struct packed {
    logic [fwir_pkg::WORD_W-1:0]  data_out;
    logic                         found;
    logic                         push_dropped;
    logic [fwir_pkg::COUNT_W-1:0] entry_count;
  } outcome_t;

  logic [fwir_pkg::WORD_W-1:0] slots [DEPTH];
  int                          held;
  int                          mismatches = 0;
  outcome_t                    awaited [$];

  assign errors = mismatches;

  // Applies one request to the shadow queue and returns the result it should give.
  function automatic outcome_t apply_request(logic [fwir_pkg::MODE_W-1:0] mode,
                                             logic [fwir_pkg::WORD_W-1:0] word,
                                             logic [fwir_pkg::POS_W-1:0]  pos);
    outcome_t o;
    int       at;
    int       i;
    o  = '0;
    at = -1;
    case (mode)
      fwir_pkg::MODE_PUSH: begin
        if (held < DEPTH) begin
          slots[IW'(held)] = word;
          held++;
        end else begin
          o.push_dropped = 1'b1;
        end
      end
      fwir_pkg::MODE_POP, fwir_pkg::MODE_PEEK: begin
        if (held > 0) at = 0;
      end
      fwir_pkg::MODE_REMOVE, fwir_pkg::MODE_READ: begin
        if (int'(pos) < held) at = int'(pos);
      end
      default: ;
    endcase
    if (at >= 0) begin
      o.found    = 1'b1;
      o.data_out = slots[IW'(at)];
      // later entries close up behind a pop or remove
      if (mode == fwir_pkg::MODE_POP || mode == fwir_pkg::MODE_REMOVE) begin
        for (i = at; i < held - 1; i++) slots[IW'(i)] = slots[IW'(i + 1)];
        held--;
      end
    end
    o.entry_count = held[fwir_pkg::COUNT_W-1:0];
    return o;
  endfunction

  task automatic check_field(string name, logic [fwir_pkg::WORD_W-1:0] want,
                             logic [fwir_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      held = 0;
      awaited.delete();
    end else begin
      // result side first, so a stray result is not hidden by a same-cycle request
      if (rsp.valid && rsp.ready) begin
        got.data_out     = rsp.data_out;
        got.found        = rsp.found;
        got.push_dropped = rsp.push_dropped;
        got.entry_count  = rsp.entry_count;
        if (awaited.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transfer with nothing expected, got %0h", $time, got);
        end else begin
          want = awaited.pop_front();
          check_field("data_out", want.data_out, got.data_out);
          check_field("found", fwir_pkg::WORD_W'(want.found), fwir_pkg::WORD_W'(got.found));
          check_field("push_dropped", fwir_pkg::WORD_W'(want.push_dropped),
                      fwir_pkg::WORD_W'(got.push_dropped));
          check_field("entry_count", fwir_pkg::WORD_W'(want.entry_count),
                      fwir_pkg::WORD_W'(got.entry_count));
        end
      end
      if (req.valid && req.ready)
        awaited.push_back(apply_request(req.mode, req.data_in, req.position));
    end
    pending <= awaited.size();
    fill    <= held;
  end

endmodule

>>> bench/fifo_with_indexed_remove_tb.sv
// Testbench top for the indexed-remove FIFO: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on fwir_pkg, the channel
// interfaces, fifo_with_indexed_remove and fifo_with_indexed_remove_checker.
module fifo_with_indexed_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH    = 16;
  localparam int RANDOM_ITEMS   = 750;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_WAIT       = 12;

  // modes the block leaves unused
  localparam logic [fwir_pkg::MODE_W-1:0] MODE_RSVD_A = 3'd5;
  localparam logic [fwir_pkg::MODE_W-1:0] MODE_RSVD_B = 3'd6;
  localparam logic [fwir_pkg::MODE_W-1:0] MODE_RSVD_C = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fwir_req_if req_ch ();
  fwir_rsp_if rsp_ch ();

  int errors;
  int pending;
  int fill;
  int idle_cycles;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fifo_with_indexed_remove #(
    .DEPTH      (QUEUE_DEPTH),
    .DATA_WIDTH (fwir_pkg::WORD_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fifo_with_indexed_remove_checker #(
    .DEPTH (QUEUE_DEPTH)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending),
    .fill    (fill)
  );

  // Wait length for one item; now and then a side flips into a run with no gaps.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_request(logic [fwir_pkg::MODE_W-1:0] mode,
                              logic [fwir_pkg::WORD_W-1:0] word,
                              logic [fwir_pkg::POS_W-1:0] pos);
    int  gap;
    bit  taken;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= mode;
    req_ch.data_in  <= word;
    req_ch.position <= pos;
    do begin
      @(negedge clk);
      taken = req_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Hold requests back until every outstanding result has been taken.
  task automatic drain;
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic send_random(int push_pct);
    int                          r;
    logic [fwir_pkg::MODE_W-1:0] mode;
    logic [fwir_pkg::WORD_W-1:0] word;
    logic [fwir_pkg::POS_W-1:0]  pos;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      mode = MODE_RSVD_A + fwir_pkg::MODE_W'($urandom_range(0, 2));
    end else if (r < 5 + push_pct) begin
      mode = fwir_pkg::MODE_PUSH;
    end else begin
      case ($urandom_range(0, 3))
        0:       mode = fwir_pkg::MODE_POP;
        1:       mode = fwir_pkg::MODE_REMOVE;
        2:       mode = fwir_pkg::MODE_PEEK;
        default: mode = fwir_pkg::MODE_READ;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    // fill is a hint only; positions mostly land inside the queue
    if ($urandom_range(0, 3) == 0 || fill == 0) pos = fwir_pkg::POS_W'($urandom_range(0, 15));
    else pos = fwir_pkg::POS_W'($urandom_range(0, fill - 1));
    send_request(mode, word, pos);
  endtask

  // result side: random stalls per transfer, with spells of none
  initial begin
    int stall;
    bit hit;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(take_calm);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        hit = rsp_ch.valid;
        @(posedge clk);
      end while (!hit);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int push_pct;
    int i;
    req_ch.valid    <= 1'b0;
    req_ch.mode     <= fwir_pkg::MODE_PUSH;
    req_ch.data_in  <= '0;
    req_ch.position <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, including the unused modes
    send_request(fwir_pkg::MODE_POP, $urandom, 4'd0);
    send_request(fwir_pkg::MODE_REMOVE, $urandom, 4'd0);
    send_request(fwir_pkg::MODE_PEEK, $urandom, 4'd15);
    send_request(fwir_pkg::MODE_READ, $urandom, 4'd15);
    send_request(MODE_RSVD_A, '1, 4'd15);
    send_request(MODE_RSVD_B, '0, 4'd0);
    send_request(MODE_RSVD_C, $urandom, fwir_pkg::POS_W'($urandom_range(0, 15)));
    // fill to the brim, then one push too many
    for (i = 0; i < QUEUE_DEPTH; i++)
      send_request(fwir_pkg::MODE_PUSH, (i == 0) ? '0 : (i == 1) ? '1 : $urandom, 4'd0);
    send_request(fwir_pkg::MODE_PUSH, $urandom, 4'd0);
    send_request(fwir_pkg::MODE_READ, $urandom, 4'd15);
    send_request(fwir_pkg::MODE_REMOVE, $urandom, 4'd15);
    send_request(fwir_pkg::MODE_READ, $urandom, 4'd15);
    send_request(fwir_pkg::MODE_REMOVE, $urandom, 4'd7);
    send_request(fwir_pkg::MODE_PEEK, $urandom, 4'd0);
    send_request(fwir_pkg::MODE_POP, $urandom, 4'd0);
    drain();

    push_pct = 50;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // phases that fill, churn or empty the queue
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 20;
          1:       push_pct = 47;
          default: push_pct = 75;
        endcase
      end
      if (i % 200 == 199) drain();
      send_random(push_pct);
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
